// File: design/address_resolution_cache_macros.svh
// Assertion macros used by the address resolution cache checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ADDRESS_RESOLUTION_CACHE_MACROS_SVH
`define ADDRESS_RESOLUTION_CACHE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ARC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("address resolution cache assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ARC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("address resolution cache assertion failed");

`endif

// File: design/arc_pkg.sv
// Types and constants of the address resolution cache.
// Depends on nothing; used by every module of the block but arc_ram.
package arc_pkg;

	localparam logic [2:0] CMD_LOOKUP = 3'd0;
	localparam logic [2:0] CMD_INSERT = 3'd1;
	localparam logic [2:0] CMD_DELETE = 3'd2;
	localparam logic [2:0] CMD_AGE    = 3'd3;
	localparam logic [2:0] CMD_GET    = 3'd4;

	localparam logic [31:0] TTL_RESET = 32'd60000;
	localparam logic [4:0]  COUNT_SAT = 5'd31;

	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] ip_address;
		logic [47:0] mac_address;
		logic [3:0]  entry_index;
		logic [31:0] now_ticks;
	} arc_in_t;

	typedef struct packed {
		logic        success;
		logic [31:0] entry_ip;
		logic [47:0] entry_mac;
		logic [31:0] entry_stamp;
		logic [4:0]  valid_count;
	} arc_out_t;

	typedef struct packed {
		logic [31:0] ip;
		logic [47:0] mac;
		logic [31:0] stamp;
	} arc_entry_t;

	localparam int ENTRY_W = $bits(arc_entry_t);

	typedef struct packed {
		logic load;
		logic rd;
		logic commit;
	} arc_cmd_t;

endpackage

// File: design/arc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the slot contents of the cache.
module arc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: design/arc_ctrl.sv
// Controller of the address resolution cache: sequences the slot scan and the commit.
// Depends on arc_pkg; drives the datapath through arc_cmd_t.
module arc_ctrl import arc_pkg::*; #(
	parameter int ENTRIES = 16,
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output arc_cmd_t      cmd,
	output logic [AW-1:0] rd_addr
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	state_t        state_q;
	logic [AW-1:0] addr_q;
	logic          out_valid_q;
	logic          out_free;

	assign out_free   = !out_valid_q || out_ready;
	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign rd_addr    = addr_q;
	assign cmd.load   = (state_q == ST_IDLE) && in_valid;
	assign cmd.rd     = (state_q == ST_SCAN);
	assign cmd.commit = (state_q == ST_COMMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			addr_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					addr_q <= '0;
					if (in_valid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (addr_q == AW'(ENTRIES - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: design/arc_datapath.sv
// Datapath of the address resolution cache: slot store, valid bits, scan results.
// Depends on arc_pkg and arc_ram; steered by arc_ctrl through arc_cmd_t.
module arc_datapath import arc_pkg::*; #(
	parameter int ENTRIES = 16,
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	localparam int CW = $clog2(ENTRIES + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  arc_cmd_t      cmd,
	input  logic [AW-1:0] rd_addr,
	input  arc_in_t       in_data,
	input  logic          cfg_we,
	input  logic [31:0]   cfg_data,
	output arc_out_t      out_data
);

	arc_in_t       item_q;
	logic [31:0]   ttl_q;
	logic [ENTRIES-1:0] valid_q;
	logic [CW-1:0] count_q;

	logic          eval_s1;
	logic [AW-1:0] slot_s1;
	logic [ENTRY_W-1:0] rd_raw;
	arc_entry_t    rd_entry;

	logic          found_q, free_found_q, min_seen_q, got_q;
	logic [AW-1:0] hit_idx_q, free_idx_q, min_idx_q;
	logic [47:0]   hit_mac_q;
	logic [31:0]   min_stamp_q;
	logic [3:0]    seen_q;
	arc_entry_t    got_q_entry;
	arc_out_t      out_q;

	logic          slot_v, age_clear;
	logic          is_ins, ins_new, del_hit;
	logic [AW-1:0] tgt_idx;
	logic [CW-1:0] count_next;
	logic [8:0]    count_ext;
	arc_entry_t    wr_entry;
	arc_out_t      res;

	assign rd_entry = arc_entry_t'(rd_raw);
	assign slot_v   = valid_q[slot_s1];
	assign age_clear = eval_s1 && (item_q.command == CMD_AGE) && slot_v
		&& ((item_q.now_ticks - rd_entry.stamp) > ttl_q);

	assign is_ins  = (item_q.command == CMD_INSERT) && (item_q.ip_address != 32'd0);
	assign ins_new = is_ins && !found_q;
	assign del_hit = (item_q.command == CMD_DELETE) && found_q;
	assign tgt_idx = found_q ? hit_idx_q : (free_found_q ? free_idx_q : min_idx_q);

	assign wr_entry.ip    = item_q.ip_address;
	assign wr_entry.mac   = item_q.mac_address;
	assign wr_entry.stamp = item_q.now_ticks;

	always_comb begin
		count_next = count_q;
		if (ins_new && free_found_q) begin
			count_next = count_q + CW'(1);
		end else if (del_hit) begin
			count_next = count_q - CW'(1);
		end
		count_ext = 9'(count_next);

		res = '0;
		res.valid_count = (count_ext > 9'(COUNT_SAT)) ? COUNT_SAT : count_ext[4:0];
		case (item_q.command)
			CMD_LOOKUP: begin
				res.success = found_q;
				res.entry_mac = found_q ? hit_mac_q : 48'd0;
			end
			CMD_DELETE: begin
				res.success = found_q;
			end
			CMD_GET: begin
				res.success = got_q;
				if (got_q) begin
					res.entry_ip    = got_q_entry.ip;
					res.entry_mac   = got_q_entry.mac;
					res.entry_stamp = got_q_entry.stamp;
				end
			end
			default: begin
				res.success = 1'b0;
			end
		endcase
	end

	arc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(ENTRIES)
	) u_slot_ram (
		.clk   (clk),
		.we    (cmd.commit && is_ins),
		.waddr (tgt_idx),
		.wdata (wr_entry),
		.re    (cmd.rd),
		.raddr (rd_addr),
		.rdata (rd_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q        <= TTL_RESET;
			valid_q      <= '0;
			count_q      <= '0;
			eval_s1      <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			min_seen_q   <= 1'b0;
			got_q        <= 1'b0;
			seen_q       <= '0;
		end else begin
			eval_s1 <= cmd.rd;
			if (cfg_we) begin
				ttl_q <= cfg_data;
			end
			if (cmd.load) begin
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
				min_seen_q   <= 1'b0;
				got_q        <= 1'b0;
				seen_q       <= '0;
			end else if (eval_s1) begin
				if (slot_v && !found_q && (rd_entry.ip == item_q.ip_address)) begin
					found_q <= 1'b1;
				end
				if (!slot_v && !free_found_q) begin
					free_found_q <= 1'b1;
				end
				if (slot_v && (!min_seen_q || (rd_entry.stamp < min_stamp_q))) begin
					min_seen_q <= 1'b1;
				end
				if (slot_v && !got_q) begin
					if (seen_q == item_q.entry_index) begin
						got_q <= 1'b1;
					end else begin
						seen_q <= seen_q + 4'd1;
					end
				end
				if (age_clear) begin
					valid_q[slot_s1] <= 1'b0;
					count_q          <= count_q - CW'(1);
				end
			end else if (cmd.commit) begin
				count_q <= count_next;
				if (ins_new) begin
					valid_q[tgt_idx] <= 1'b1;
				end
				if (del_hit) begin
					valid_q[hit_idx_q] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= rd_addr;
		if (cmd.load) begin
			item_q <= in_data;
		end
		if (eval_s1) begin
			if (slot_v && !found_q && (rd_entry.ip == item_q.ip_address)) begin
				hit_idx_q <= slot_s1;
				hit_mac_q <= rd_entry.mac;
			end
			if (!slot_v && !free_found_q) begin
				free_idx_q <= slot_s1;
			end
			if (slot_v && (!min_seen_q || (rd_entry.stamp < min_stamp_q))) begin
				min_idx_q   <= slot_s1;
				min_stamp_q <= rd_entry.stamp;
			end
			if (slot_v && !got_q && (seen_q == item_q.entry_index)) begin
				got_q_entry <= rd_entry;
			end
		end
		if (cmd.commit) begin
			out_q <= res;
		end
	end

	assign out_data = out_q;

endmodule

// File: design/address_resolution_cache.sv
// Top level of the address resolution cache: an IPv4-to-MAC table with aging.
// Depends on arc_pkg, arc_ctrl, arc_datapath and arc_ram.
//
// Commands arrive on the in channel (in_valid, in_ready, in_data) and each
// yields exactly one result on the out channel (out_valid, out_ready, out_data).
// The entry lifetime is written through cfg_valid, cfg_ready and cfg_data;
// cfg_ready is always high, and writes are expected only while the block is idle.
// Each command scans every slot through one read port of the slot RAM, one slot
// per cycle, then passes a drain step and a commit step before its result is
// shown; a new command is taken only after the previous one has committed.
// The result waits in an output register; if the receiver stalls, the next
// command is still accepted and scanned, and it holds in its commit step until
// the earlier result has been transferred.
// Reset clears all valid bits and the entry count at once and restores the
// lifetime to 60000 ticks; slot contents stay undefined until written.
module address_resolution_cache import arc_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  arc_in_t     in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output arc_out_t    out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	arc_cmd_t      cmd;
	logic [AW-1:0] rd_addr;

	assign cfg_ready = 1'b1;

	arc_ctrl #(
		.ENTRIES(ENTRIES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.rd_addr   (rd_addr)
	);

	arc_datapath #(
		.ENTRIES(ENTRIES)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.rd_addr  (rd_addr),
		.in_data  (in_data),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.out_data (out_data)
	);

endmodule

// File: design/arc_checker.sv
// Port-level checker of the address resolution cache, bound to the top level.
// Depends on arc_pkg and address_resolution_cache_macros.svh.
`include "address_resolution_cache_macros.svh"

module arc_checker import arc_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input arc_out_t out_data
);

	// A stalled result keeps its payload.
	`ARC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))

	// Only one command is worked on at a time.
	`ARC_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready)

	// The entry count never exceeds the table size.
	`ARC_ASSERT_IMPLY(a_count_range, clk, arst_n, out_valid, 32'(out_data.valid_count) <= ENTRIES)

	// A failed command returns no entry data.
	`ARC_ASSERT_IMPLY(a_fail_zero, clk, arst_n, out_valid && !out_data.success, (out_data.entry_ip == 32'd0) && (out_data.entry_mac == 48'd0) && (out_data.entry_stamp == 32'd0))

endmodule

bind address_resolution_cache arc_checker #(
	.ENTRIES(ENTRIES)
) u_arc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
